>>> design/sbds_pkg.sv
`default_nettype none

package sbds_pkg;

  // Display geometry
  localparam int OUT_BINS    = 1024;
  localparam int IDX_W       = $clog2(OUT_BINS);
  localparam int CNT_W       = $clog2(OUT_BINS + 1);
  localparam int MAX_RESULTS = 64;
  localparam int MIN_LEN_RAW = (OUT_BINS + MAX_RESULTS - 1) / MAX_RESULTS;
  localparam int MIN_LEN     = (MIN_LEN_RAW < 16) ? 16 : MIN_LEN_RAW;

  // Field widths
  localparam int VAL_W   = 24;
  localparam int LEN_W   = 16;
  localparam int COEF_W  = 17;
  localparam int ACC_W   = LEN_W + 1;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int PROD_W  = DIFF_W + COEF_W + 1;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = PROD_W - FRAC_W;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_LEN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECAY     = 2'd2;

  localparam logic [LEN_W-1:0]  FRAME_LEN_RST = LEN_W'(1024);
  localparam logic [COEF_W-1:0] ATTACK_RST    = COEF_W'(13107);
  localparam logic [COEF_W-1:0] DECAY_RST     = COEF_W'(19661);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } step_state_t;

  // One display bin on its way into the smoothing pipeline
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] x;
    logic                    first;
  } bin_req_t;

endpackage

`default_nettype wire

>>> design/sbds_bin_pipe.sv
`default_nettype none

module sbds_bin_pipe (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              req_valid,
  output logic                             req_ready,
  input  wire sbds_pkg::bin_req_t          req,
  input  wire [sbds_pkg::COEF_W-1:0]       attack_coef,
  input  wire [sbds_pkg::COEF_W-1:0]       decay_coef,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [sbds_pkg::IDX_W-1:0]       out_idx,
  output logic signed [sbds_pkg::VAL_W-1:0] out_value,
  output logic                             out_last
);
  import sbds_pkg::*;

  // Smoothed display bins; the read is registered in rd_data_r ahead of the arithmetic
  logic signed [VAL_W-1:0] mem [OUT_BINS];
  logic signed [VAL_W-1:0] rd_data_r;

  logic                     s1_valid_r, s1_valid_nxt;
  bin_req_t                 s1_req_r;
  logic                     s2_valid_r, s2_valid_nxt;
  bin_req_t                 s2_req_r;
  logic signed [VAL_W-1:0]  s2_old_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [VAL_W-1:0]  out_value_r;

  logic rd_en, wr_en;
  logic s1_free, s2_free, advance_out, s1_move, s2_move;

  logic signed [DIFF_W-1:0] diff;
  logic signed [COEF_W:0]   ratio_s;
  logic [COEF_W-1:0]        ratio_raw;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  q;
  logic signed [SUM_W-1:0]  sum;
  logic signed [VAL_W-1:0]  s2_value;

  // Stall control: each stage moves when the one after it can take the bin
  assign advance_out = !out_valid_r || out_ready;
  assign s2_free     = !s2_valid_r || advance_out;
  assign s2_move     = s2_valid_r && advance_out;
  assign s1_move     = s1_valid_r && s2_free;
  assign s1_free     = !s1_valid_r || s2_free;
  assign req_ready   = s1_free;
  assign rd_en       = req_valid && s1_free;
  assign wr_en       = s2_move;

  assign s1_valid_nxt  = s1_free ? rd_en : 1'b1;
  assign s2_valid_nxt  = s2_free ? s1_valid_r : 1'b1;
  assign out_valid_nxt = advance_out ? s2_valid_r : 1'b1;

  // Stage 1: pick the ratio and multiply the step toward the new maximum
  always_comb begin
    diff      = DIFF_W'(s1_req_r.x) - DIFF_W'(rd_data_r);
    ratio_raw = (s1_req_r.x > rd_data_r) ? attack_coef : decay_coef;
    ratio_s   = $signed({1'b0, (ratio_raw[COEF_W-1] ? COEF_ONE : ratio_raw)});
    prod      = diff * ratio_s;
  end

  // Stage 2: floor shift and add back to the stored value (first frame: raw x)
  always_comb begin
    q        = s2_prod_r[PROD_W-1:FRAC_W];
    sum      = SUM_W'(s2_old_r) + q;
    s2_value = s2_req_r.first ? s2_req_r.x : sum[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[req.idx];
    end
    if (wr_en) begin
      mem[s2_req_r.idx] <= s2_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_req_r <= req;
    end
    if (s1_move) begin
      s2_req_r  <= s1_req_r;
      s2_old_r  <= rd_data_r;
      s2_prod_r <= prod;
    end
    if (s2_move) begin
      out_idx_r   <= s2_req_r.idx;
      out_value_r <= s2_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_value = out_value_r;
  assign out_last  = (out_idx_r == IDX_W'(OUT_BINS - 1));

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en |-> req.idx != s2_req_r.idx)
    else $error("read and write of the same bin in one cycle");

  a_smooth_between: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_req_r.first |->
      ((s2_value >= s2_old_r && s2_value <= s2_req_r.x) ||
       (s2_value <= s2_old_r && s2_value >= s2_req_r.x)))
    else $error("smoothed value outside old and new value");

  a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> s2_valid_r && s2_req_r == $past(s1_req_r))
    else $error("stage 1 bin lost on its way to stage 2");

endmodule

`default_nettype wire

>>> design/spectrum_bin_decimate_smooth_top.sv
`default_nettype none

// Spectrum bin decimator with attack/decay smoothing. Power bins (signed Q16.8)
// arrive one per transfer and are counted into frames of frame_len bins; each
// frame is resampled to 1024 display bins, each holding the maximum of the
// input bins that fall into it. Every display bin is smoothed against its
// stored value in an on-chip RAM: new = old + floor((in - old) * ratio / 65536),
// with attack_coef when rising and decay_coef otherwise (Q1.16, values above
// 65536 act as 1.0). The first frame after reset or after any register write
// passes through unsmoothed and fills the RAM, so the RAM needs no clearing
// pass. A frame_len below 16 acts as 16. An input item is handled in steps:
// the bin is taken and the running maximum updated, each display bin that it
// completes is issued into the read-multiply-write pipeline of the smoothing
// RAM, and the step is closed; a stalled output holds the issue. No new input
// is taken until the step closes. With frame_len = 1024 each input bin
// completes exactly one display bin. Write registers only while no frame work
// is pending; any write restarts the frame.
module spectrum_bin_decimate_smooth_top (
  input  wire                                clk,
  input  wire                                rst_n,
  // input power bins
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [sbds_pkg::IN_TDATA_W-1:0]     in_tdata,   // [23:0] power_in
  // display bins
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [sbds_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [9:0] bin_index, [33:10] bin_value
  output logic                               out_tlast,  // frame_last
  // register port
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire [sbds_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire [sbds_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [sbds_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import sbds_pkg::*;

  // Configuration registers
  logic [LEN_W-1:0]  frame_len_r;
  logic [COEF_W-1:0] attack_coef_r;
  logic [COEF_W-1:0] decay_coef_r;

  logic                 cfg_wr;
  logic                 cfg_restart;
  logic [REG_IDX_W-1:0] cfg_idx;

  // Step control
  step_state_t             state_r, state_nxt;
  logic signed [VAL_W-1:0] running_max_r, running_max_nxt;
  logic                    restart_max_r, restart_max_nxt;
  logic                    first_frame_r, first_frame_nxt;
  logic                    frame_end_r, frame_end_nxt;
  logic [LEN_W-1:0]        in_count_r, in_count_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;

  logic [LEN_W-1:0]        len_eff;
  logic [ACC_W-1:0]        len_ext;
  logic [ACC_W-1:0]        acc_sum;
  logic [LEN_W-1:0]        pos;
  logic signed [VAL_W-1:0] x;
  logic                    emit_pend;

  logic                    req_valid, req_ready;
  bin_req_t                req;
  logic [IDX_W-1:0]        bin_idx;
  logic signed [VAL_W-1:0] bin_value;

  assign cfg_pready  = 1'b1;
  assign cfg_idx     = cfg_paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_restart = cfg_wr && (cfg_idx == REG_FRAME_LEN || cfg_idx == REG_ATTACK ||
                                  cfg_idx == REG_DECAY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r   <= FRAME_LEN_RST;
      attack_coef_r <= ATTACK_RST;
      decay_coef_r  <= DECAY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_LEN: frame_len_r   <= cfg_pwdata[LEN_W-1:0];
        REG_ATTACK:    attack_coef_r <= cfg_pwdata[COEF_W-1:0];
        REG_DECAY:     decay_coef_r  <= cfg_pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_LEN: cfg_prdata = CFG_DATA_W'(frame_len_r);
      REG_ATTACK:    cfg_prdata = CFG_DATA_W'(attack_coef_r);
      REG_DECAY:     cfg_prdata = CFG_DATA_W'(decay_coef_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Clamp short frames so each input bin completes at most 64 display bins
  assign len_eff = (frame_len_r < LEN_W'(MIN_LEN)) ? LEN_W'(MIN_LEN) : frame_len_r;
  assign len_ext = ACC_W'(len_eff);

  // The display index target floor(pos * OUT_BINS / len) is tracked as a
  // remainder: add OUT_BINS per input bin, then subtract len once for every
  // display bin emitted, one per cycle while the smoothing pipeline accepts it.
  assign acc_sum   = acc_r + ACC_W'(OUT_BINS);
  assign pos       = in_count_r + 1'b1;
  assign x         = $signed(in_tdata[VAL_W-1:0]);
  assign emit_pend = (acc_r >= len_ext);

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    running_max_nxt = running_max_r;
    restart_max_nxt = restart_max_r;
    first_frame_nxt = first_frame_r;
    frame_end_nxt   = frame_end_r;
    in_count_nxt    = in_count_r;
    out_count_nxt   = out_count_r;
    acc_nxt         = acc_r;
    req_valid       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (restart_max_r || x > running_max_r) begin
            running_max_nxt = x;
          end
          acc_nxt         = acc_sum;
          frame_end_nxt   = (pos >= len_eff);
          restart_max_nxt = (acc_sum >= len_ext);
          state_nxt       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_pend) begin
          req_valid = 1'b1;
          if (req_ready) begin
            acc_nxt       = acc_r - len_ext;
            out_count_nxt = out_count_r + 1'b1;
          end
        end else begin
          // close the step; wrap the frame after its last input bin
          if (frame_end_r) begin
            in_count_nxt    = '0;
            out_count_nxt   = '0;
            acc_nxt         = '0;
            first_frame_nxt = 1'b0;
            restart_max_nxt = 1'b1;
          end else begin
            in_count_nxt = pos;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a register write restarts the frame
    if (cfg_restart) begin
      first_frame_nxt = 1'b1;
      running_max_nxt = '0;
      restart_max_nxt = 1'b1;
      in_count_nxt    = '0;
      out_count_nxt   = '0;
      acc_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      running_max_r <= '0;
      restart_max_r <= 1'b1;
      first_frame_r <= 1'b1;
      frame_end_r   <= 1'b0;
      in_count_r    <= '0;
      out_count_r   <= '0;
      acc_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      running_max_r <= running_max_nxt;
      restart_max_r <= restart_max_nxt;
      first_frame_r <= first_frame_nxt;
      frame_end_r   <= frame_end_nxt;
      in_count_r    <= in_count_nxt;
      out_count_r   <= out_count_nxt;
      acc_r         <= acc_nxt;
    end
  end

  always_comb begin
    req.idx   = out_count_r[IDX_W-1:0];
    req.x     = running_max_r;
    req.first = first_frame_r;
  end

  sbds_bin_pipe u_bin_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .attack_coef (attack_coef_r),
    .decay_coef  (decay_coef_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_idx     (bin_idx),
    .out_value   (bin_value),
    .out_last    (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - VAL_W - IDX_W)'(0), bin_value, bin_idx};

  a_idle_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> acc_r < len_ext)
    else $error("display target remainder not reduced at step end");

  a_issue_advances: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready && !cfg_restart |=> out_count_r == $past(out_count_r) + 1'b1)
    else $error("display bin issued without advancing the count");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_restart |=> in_count_r == '0 && out_count_r == '0 && first_frame_r && restart_max_r)
    else $error("register write did not restart the frame");

endmodule

`default_nettype wire
